// ===== rtl/core/lobm_pkg.sv =====
// shared types and constants for the limit order book matcher
package lobm_pkg;

   localparam int MAX_ORDERS = 64;
   localparam int SLOT_W     = $clog2(MAX_ORDERS);
   localparam int CNT_W      = $clog2(MAX_ORDERS + 1);
   localparam int RESULT_CAP = 64;
   localparam int RES_W      = $clog2(RESULT_CAP + 1);

   typedef enum logic [1:0] {
      OP_SUBMIT = 2'd0,
      OP_CANCEL = 2'd1,
      OP_LIST   = 2'd2,
      OP_TOP    = 2'd3
   } op_type;

   localparam logic [2:0] KIND_MATCH     = 3'd0;
   localparam logic [2:0] KIND_RESTED    = 3'd1;
   localparam logic [2:0] KIND_CANCELLED = 3'd2;
   localparam logic [2:0] KIND_MISS      = 3'd3;
   localparam logic [2:0] KIND_LISTED    = 3'd4;
   localparam logic [2:0] KIND_EMPTY     = 3'd5;
   localparam logic [2:0] KIND_FULL      = 3'd6;
   localparam logic [2:0] KIND_TOP       = 3'd7;

   typedef struct packed {
      op_type      op;
      logic        side;
      logic [31:0] quantity;
      logic [31:0] price;
      logic [31:0] customer;
      logic [31:0] target_id;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

   typedef struct packed {
      logic [31:0] id;
      logic        side;
      logic [31:0] price;
      logic [31:0] quantity;
      logic [31:0] customer;
   } order_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] first_id;
      logic        first_side;
      logic [31:0] first_price;
      logic [31:0] first_quantity;
      logic [31:0] first_customer;
      logic [31:0] second_id;
      logic [31:0] second_price;
      logic [31:0] second_quantity;
      logic [31:0] second_customer;
      logic [31:0] fill_quantity;
      logic        last;
   } rsp_type;

endpackage

// ===== rtl/core/limit_order_book_matcher_top.sv =====
// A bounded limit order book with price-time priority matching. Items are taken
// with start while busy is low and wait in a two-entry queue; results come out as
// one-cycle rsp_valid strobes that cannot be held off, and rsp_last marks the final
// result of each item. Every scan pass reads the 64-entry order memory one slot
// per cycle, then makes its decision. A submit first searches for a free slot and
// writes the new order, then per match runs a pass, its decision and the ask and
// bid update steps, and ends with one closing pass; a cancel or top-of-book query
// takes one pass, a list one pass per listed order plus one. Sustained cost is set
// by that memory scan.
module limit_order_book_matcher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic        req_side,
   input  logic [31:0] req_quantity,
   input  logic [31:0] req_price,
   input  logic [31:0] req_customer,
   input  logic [31:0] req_target_id,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_first_id,
   output logic        rsp_first_side,
   output logic [31:0] rsp_first_price,
   output logic [31:0] rsp_first_quantity,
   output logic [31:0] rsp_first_customer,
   output logic [31:0] rsp_second_id,
   output logic [31:0] rsp_second_price,
   output logic [31:0] rsp_second_quantity,
   output logic [31:0] rsp_second_customer,
   output logic [31:0] rsp_fill_quantity,
   output logic        rsp_last
);

   lobm_pkg::cmd_type       cmd;
   lobm_pkg::queue_out_type q_out;
   lobm_pkg::rsp_type       rsp;
   logic                    pop;

   assign cmd.op        = lobm_pkg::op_type'(req_opcode);
   assign cmd.side      = req_side;
   assign cmd.quantity  = req_quantity;
   assign cmd.price     = req_price;
   assign cmd.customer  = req_customer;
   assign cmd.target_id = req_target_id;

   lobm_front u_front (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .pop   (pop),
      .q_out (q_out)
   );

   lobm_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_in      (q_out),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_kind            = rsp.kind;
   assign rsp_first_id        = rsp.first_id;
   assign rsp_first_side      = rsp.first_side;
   assign rsp_first_price     = rsp.first_price;
   assign rsp_first_quantity  = rsp.first_quantity;
   assign rsp_first_customer  = rsp.first_customer;
   assign rsp_second_id       = rsp.second_id;
   assign rsp_second_price    = rsp.second_price;
   assign rsp_second_quantity = rsp.second_quantity;
   assign rsp_second_customer = rsp.second_customer;
   assign rsp_fill_quantity   = rsp.fill_quantity;
   assign rsp_last            = rsp.last;

endmodule

// ===== rtl/core/lobm_front.sv =====
// command intake and two-entry queue toward the matching engine
module lobm_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  lobm_pkg::cmd_type      cmd,
   input  logic                   pop,
   output lobm_pkg::queue_out_type q_out
);

   lobm_pkg::cmd_type q_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic              push;
   logic              do_pop;

   assign busy   = (count_ff == 2'd2);
   assign push   = start && !busy;
   assign do_pop = pop && (count_ff != 2'd0);

   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.cmd   = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, do_pop};
      end
   end

endmodule

// ===== rtl/core/lobm_engine.sv =====
// order book storage, scan passes and result sequencing
module lobm_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  lobm_pkg::queue_out_type q_in,
   output logic                    pop,
   output logic                    rsp_valid,
   output lobm_pkg::rsp_type       rsp
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FREE,
      ST_WRNEW,
      ST_SCAN,
      ST_DECIDE,
      ST_UPD_A,
      ST_UPD_B,
      ST_FLUSH
   } state_type;

   state_type                      state_ff;
   lobm_pkg::order_type            mem [lobm_pkg::MAX_ORDERS];
   logic [lobm_pkg::MAX_ORDERS-1:0] valid_ff;
   lobm_pkg::cmd_type              cmd_ff;
   logic [31:0]                    next_id_ff;
   logic [lobm_pkg::CNT_W-1:0]     free_ff;
   logic [lobm_pkg::CNT_W-1:0]     scan_addr_ff;
   lobm_pkg::order_type            rd_ff;
   logic                           rd_live_ff;
   logic                           rd_sv_ff;
   logic [lobm_pkg::SLOT_W-1:0]    rd_idx_ff;
   lobm_pkg::order_type            a_ff;
   lobm_pkg::order_type            b_ff;
   logic                           a_found_ff;
   logic                           b_found_ff;
   logic [lobm_pkg::SLOT_W-1:0]    a_idx_ff;
   logic [lobm_pkg::SLOT_W-1:0]    b_idx_ff;
   lobm_pkg::order_type            new_ff;
   logic [31:0]                    fill_ff;
   logic [31:0]                    thr_ff;
   logic                           thr_has_ff;
   lobm_pkg::rsp_type              pend_ff;
   logic                           pend_has_ff;
   logic [lobm_pkg::RES_W-1:0]     res_cnt_ff;
   lobm_pkg::rsp_type              rsp_ff;
   logic                           rsp_valid_ff;

   logic [31:0]                    key_rd;
   logic [31:0]                    key_a;
   logic [31:0]                    key_b;
   logic                           ask_better;
   logic                           bid_better;
   logic                           hit_better;
   logic                           list_better;
   logic [31:0]                    fill;
   logic                           crossed;
   logic                           mem_we;
   logic [lobm_pkg::SLOT_W-1:0]    mem_wa;
   lobm_pkg::order_type            mem_wd;
   lobm_pkg::order_type            a_upd;
   lobm_pkg::order_type            b_upd;

   function automatic lobm_pkg::rsp_type blank(input logic [2:0] kind);
      lobm_pkg::rsp_type r;
      r      = '0;
      r.kind = kind;
      return r;
   endfunction

   function automatic lobm_pkg::rsp_type as_last(input lobm_pkg::rsp_type r_in);
      lobm_pkg::rsp_type r;
      r      = r_in;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic lobm_pkg::rsp_type with_first(input lobm_pkg::rsp_type r_in,
                                                   input lobm_pkg::order_type o);
      lobm_pkg::rsp_type r;
      r                = r_in;
      r.first_id       = o.id;
      r.first_side     = o.side;
      r.first_price    = o.price;
      r.first_quantity = o.quantity;
      r.first_customer = o.customer;
      return r;
   endfunction

   function automatic lobm_pkg::rsp_type with_second(input lobm_pkg::rsp_type r_in,
                                                    input lobm_pkg::order_type o);
      lobm_pkg::rsp_type r;
      r                 = r_in;
      r.second_id       = o.id;
      r.second_price    = o.price;
      r.second_quantity = o.quantity;
      r.second_customer = o.customer;
      return r;
   endfunction

   // age key: distance past next id, smaller is older, survives id wrap
   assign key_rd = rd_ff.id - next_id_ff;
   assign key_a  = a_ff.id - next_id_ff;
   assign key_b  = b_ff.id - next_id_ff;

   assign ask_better = rd_ff.side &&
      (!a_found_ff || (rd_ff.price < a_ff.price) ||
       ((rd_ff.price == a_ff.price) && (key_rd < key_a)));
   assign bid_better = !rd_ff.side &&
      (!b_found_ff || (rd_ff.price > b_ff.price) ||
       ((rd_ff.price == b_ff.price) && (key_rd < key_b)));
   assign hit_better = (rd_ff.id == cmd_ff.target_id) &&
      (!a_found_ff || (key_rd < key_a));
   assign list_better = (rd_ff.customer == cmd_ff.customer) &&
      (!thr_has_ff || (key_rd > thr_ff)) &&
      (!a_found_ff || (key_rd < key_a));

   assign fill    = (a_ff.quantity < b_ff.quantity) ? a_ff.quantity : b_ff.quantity;
   assign crossed = a_found_ff && b_found_ff && (a_ff.price <= b_ff.price);

   always_comb begin
      a_upd          = a_ff;
      a_upd.quantity = a_ff.quantity - fill_ff;
      b_upd          = b_ff;
      b_upd.quantity = b_ff.quantity - fill_ff;
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = a_idx_ff;
      mem_wd = a_upd;
      case (state_ff)
         ST_WRNEW: begin
            mem_we = 1'b1;
            mem_wa = free_ff[lobm_pkg::SLOT_W-1:0];
            mem_wd = new_ff;
         end
         ST_UPD_A: begin
            mem_we = 1'b1;
         end
         ST_UPD_B: begin
            mem_we = 1'b1;
            mem_wa = b_idx_ff;
            mem_wd = b_upd;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[scan_addr_ff[lobm_pkg::SLOT_W-1:0]];
   end

   assign pop       = (state_ff == ST_IDLE) && q_in.valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         next_id_ff   <= 32'd1;
         rsp_valid_ff <= 1'b0;
         pend_has_ff  <= 1'b0;
         thr_has_ff   <= 1'b0;
         res_cnt_ff   <= '0;
         rd_live_ff   <= 1'b0;
         a_found_ff   <= 1'b0;
         b_found_ff   <= 1'b0;
         scan_addr_ff <= '0;
         free_ff      <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (q_in.valid) begin
                  cmd_ff       <= q_in.cmd;
                  pend_has_ff  <= 1'b0;
                  thr_has_ff   <= 1'b0;
                  res_cnt_ff   <= '0;
                  free_ff      <= '0;
                  scan_addr_ff <= '0;
                  rd_live_ff   <= 1'b0;
                  a_found_ff   <= 1'b0;
                  b_found_ff   <= 1'b0;
                  if (q_in.cmd.op == lobm_pkg::OP_SUBMIT) begin
                     state_ff <= ST_FREE;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_FREE: begin
               if (!valid_ff[free_ff[lobm_pkg::SLOT_W-1:0]]) begin
                  new_ff.id       <= next_id_ff;
                  new_ff.side     <= cmd_ff.side;
                  new_ff.price    <= cmd_ff.price;
                  new_ff.quantity <= cmd_ff.quantity;
                  new_ff.customer <= cmd_ff.customer;
                  state_ff        <= ST_WRNEW;
               end else if (free_ff == lobm_pkg::CNT_W'(lobm_pkg::MAX_ORDERS - 1)) begin
                  rsp_ff <= '{kind: lobm_pkg::KIND_FULL, first_side: cmd_ff.side,
                              first_price: cmd_ff.price,
                              first_quantity: cmd_ff.quantity,
                              first_customer: cmd_ff.customer, last: 1'b1,
                              default: '0};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  free_ff <= free_ff + 1'b1;
               end
            end
            ST_WRNEW: begin
               valid_ff[free_ff[lobm_pkg::SLOT_W-1:0]] <= 1'b1;
               next_id_ff   <= next_id_ff + 32'd1;
               scan_addr_ff <= '0;
               rd_live_ff   <= 1'b0;
               a_found_ff   <= 1'b0;
               b_found_ff   <= 1'b0;
               state_ff     <= ST_SCAN;
            end
            ST_SCAN: begin
               if (scan_addr_ff != lobm_pkg::CNT_W'(lobm_pkg::MAX_ORDERS)) begin
                  rd_live_ff   <= 1'b1;
                  rd_sv_ff     <= valid_ff[scan_addr_ff[lobm_pkg::SLOT_W-1:0]];
                  rd_idx_ff    <= scan_addr_ff[lobm_pkg::SLOT_W-1:0];
                  scan_addr_ff <= scan_addr_ff + 1'b1;
               end else begin
                  rd_live_ff <= 1'b0;
                  if (!rd_live_ff) begin
                     state_ff <= ST_DECIDE;
                  end
               end
               if (rd_live_ff && rd_sv_ff) begin
                  case (cmd_ff.op)
                     lobm_pkg::OP_CANCEL: begin
                        if (hit_better) begin
                           a_ff <= rd_ff; a_idx_ff <= rd_idx_ff; a_found_ff <= 1'b1;
                        end
                     end
                     lobm_pkg::OP_LIST: begin
                        if (list_better) begin
                           a_ff <= rd_ff; a_idx_ff <= rd_idx_ff; a_found_ff <= 1'b1;
                        end
                     end
                     default: begin
                        if (ask_better) begin
                           a_ff <= rd_ff; a_idx_ff <= rd_idx_ff; a_found_ff <= 1'b1;
                        end
                        if (bid_better) begin
                           b_ff <= rd_ff; b_idx_ff <= rd_idx_ff; b_found_ff <= 1'b1;
                        end
                     end
                  endcase
               end
            end
            ST_DECIDE: begin
               case (cmd_ff.op)
                  lobm_pkg::OP_SUBMIT: begin
                     if (crossed) begin
                        if (pend_has_ff) begin
                           rsp_ff       <= pend_ff;
                           rsp_valid_ff <= 1'b1;
                        end
                        pend_ff <= with_second(with_first(
                           '{kind: lobm_pkg::KIND_MATCH, fill_quantity: fill,
                             default: '0}, a_ff), b_ff);
                        pend_has_ff <= 1'b1;
                        res_cnt_ff  <= res_cnt_ff + 1'b1;
                        fill_ff     <= fill;
                        state_ff    <= ST_UPD_A;
                     end else begin
                        if (pend_has_ff) begin
                           rsp_ff <= as_last(pend_ff);
                        end else begin
                           rsp_ff <= as_last(with_first(blank(lobm_pkg::KIND_RESTED),
                                                        new_ff));
                        end
                        rsp_valid_ff <= 1'b1;
                        pend_has_ff  <= 1'b0;
                        state_ff     <= ST_IDLE;
                     end
                  end
                  lobm_pkg::OP_CANCEL: begin
                     if (a_found_ff) begin
                        rsp_ff <= as_last(with_first(blank(lobm_pkg::KIND_CANCELLED),
                                                     a_ff));
                        valid_ff[a_idx_ff] <= 1'b0;
                     end else begin
                        rsp_ff <= '{kind: lobm_pkg::KIND_MISS,
                                    first_id: cmd_ff.target_id, last: 1'b1,
                                    default: '0};
                     end
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
                  lobm_pkg::OP_LIST: begin
                     if (a_found_ff) begin
                        if (pend_has_ff) begin
                           rsp_ff       <= pend_ff;
                           rsp_valid_ff <= 1'b1;
                        end
                        pend_ff      <= with_first(blank(lobm_pkg::KIND_LISTED), a_ff);
                        pend_has_ff  <= 1'b1;
                        res_cnt_ff   <= res_cnt_ff + 1'b1;
                        thr_ff       <= key_a;
                        thr_has_ff   <= 1'b1;
                        scan_addr_ff <= '0;
                        rd_live_ff   <= 1'b0;
                        a_found_ff   <= 1'b0;
                        if (res_cnt_ff + 1'b1 == lobm_pkg::RES_W'(lobm_pkg::RESULT_CAP)) begin
                           state_ff <= ST_FLUSH;
                        end else begin
                           state_ff <= ST_SCAN;
                        end
                     end else begin
                        if (pend_has_ff) begin
                           rsp_ff <= as_last(pend_ff);
                        end else begin
                           rsp_ff <= '{kind: lobm_pkg::KIND_EMPTY,
                                       first_customer: cmd_ff.customer, last: 1'b1,
                                       default: '0};
                        end
                        rsp_valid_ff <= 1'b1;
                        pend_has_ff  <= 1'b0;
                        state_ff     <= ST_IDLE;
                     end
                  end
                  default: begin
                     rsp_ff <= as_last(with_second(with_first(blank(lobm_pkg::KIND_TOP),
                                  a_found_ff ? a_ff : '0), b_found_ff ? b_ff : '0));
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
               endcase
            end
            ST_UPD_A: begin
               if (a_ff.quantity == fill_ff) begin
                  valid_ff[a_idx_ff] <= 1'b0;
               end
               state_ff <= ST_UPD_B;
            end
            ST_UPD_B: begin
               if (b_ff.quantity == fill_ff) begin
                  valid_ff[b_idx_ff] <= 1'b0;
               end
               scan_addr_ff <= '0;
               rd_live_ff   <= 1'b0;
               a_found_ff   <= 1'b0;
               b_found_ff   <= 1'b0;
               if (res_cnt_ff == lobm_pkg::RES_W'(lobm_pkg::RESULT_CAP)) begin
                  state_ff <= ST_FLUSH;
               end else begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_FLUSH: begin
               rsp_ff       <= as_last(pend_ff);
               rsp_valid_ff <= 1'b1;
               pend_has_ff  <= 1'b0;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_flush_ends_item: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH |=> rsp_valid_ff && rsp_ff.last)
      else $error("flush did not deliver the final result");

   a_cap_bound: assert property (@(posedge clock) disable iff (reset)
      res_cnt_ff <= lobm_pkg::RES_W'(lobm_pkg::RESULT_CAP))
      else $error("result count past cap");

   a_fill_two_slots: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPD_A |-> a_idx_ff != b_idx_ff && a_ff.side && !b_ff.side)
      else $error("match updates one slot twice or wrong sides");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_has_ff)
      else $error("pending result left over at idle");

endmodule
